FILE: rtl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// shared constants, codes and controller/datapath interface types for the
// keyed record table
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int unsigned Depth     = 64;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = 7;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned NameBytes = 49;
  localparam int unsigned NameW     = 8 * NameBytes;
  localparam int unsigned RecW      = NameW + KeyW;
  localparam int unsigned InDataW   = RecW;
  localparam int unsigned OutDataW  = 400;

  // operation codes carried on the input tuser
  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpDelete = 2'd1;
  localparam logic [1:0] OpSelect = 2'd2;
  localparam logic [1:0] OpUpdate = 2'd3;

  // result status codes carried on the output tuser
  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StDup     = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StMissing = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       scan_en;
    logic       rd_last;
    logic       wr_ins;
    logic       wr_upd;
    logic       wr_move;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       load_out;
    logic       sel_name;
    logic [1:0] out_status;
  } krt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic slot_is_last;
    logic full;
    logic out_free;
  } krt_stat_t;

endpackage

FILE: rtl/krt_datapath.sv
// ----------------------------------------------------------------------------
// krt_datapath
// record memory, key scan, record counter and output word register
// ----------------------------------------------------------------------------
module krt_datapath
  import krt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  in_data_i,
  input  krt_cmd_t            cmd_i,
  output krt_stat_t           stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic [1:0]          out_status_o
);

  // clear every name byte after the first zero byte
  function automatic logic [NameW-1:0] clip_name(input logic [NameW-1:0] n);
    logic [NameW-1:0] r;
    logic             ended;
    r     = '0;
    ended = 1'b0;
    for (int b = 0; b < NameBytes; b++) begin
      if (!ended) begin
        r[8*b +: 8] = n[8*b +: 8];
      end
      if (n[8*b +: 8] == 8'd0) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

  logic [RecW-1:0]     rec_mem [Depth];
  logic [RecW-1:0]     rd_q;
  logic [InDataW-1:0]  in_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [IdxW-1:0]     pend_idx_q, pend_idx_d;
  logic                found_q, found_d;
  logic [IdxW-1:0]     slot_q, slot_d;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic [1:0]          out_status_q;

  logic [CntW-1:0]     cnt_m1;
  logic [IdxW-1:0]     last_idx;
  logic                hit;
  logic                scan_issue;
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  logic [RecW-1:0]     wr_data;
  logic [NameW-1:0]    out_name;

  assign cnt_m1     = count_q - 1'b1;
  assign last_idx   = cnt_m1[IdxW-1:0];
  assign hit        = pend_q && (rd_q[KeyW-1:0] == in_q[KeyW-1:0]);
  assign scan_issue = cmd_i.scan_en && !hit && (idx_q < count_q);
  assign rd_en      = scan_issue || cmd_i.rd_last;
  assign rd_addr    = cmd_i.rd_last ? last_idx : idx_q[IdxW-1:0];

  always_comb begin
    wr_en   = cmd_i.wr_ins || cmd_i.wr_upd || cmd_i.wr_move;
    wr_addr = cmd_i.wr_ins ? count_q[IdxW-1:0] : slot_q;
    wr_data = cmd_i.wr_move ? rd_q
                            : {clip_name(in_q[RecW-1:KeyW]), in_q[KeyW-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rec_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= rec_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
  end

  // scan bookkeeping and record count
  always_comb begin
    count_d    = count_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    found_d    = found_q;
    slot_d     = slot_q;
    if (cmd_i.capture) begin
      idx_d   = '0;
      pend_d  = 1'b0;
      found_d = 1'b0;
    end else if (cmd_i.scan_en) begin
      pend_d     = scan_issue;
      pend_idx_d = idx_q[IdxW-1:0];
      if (scan_issue) begin
        idx_d = idx_q + 1'b1;
      end
      if (hit) begin
        found_d = 1'b1;
        slot_d  = pend_idx_q;
      end
    end
    if (cmd_i.cnt_inc) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    slot_q     <= slot_d;
  end

  // output word register
  assign out_name = cmd_i.sel_name ? rd_q[RecW-1:KeyW] : '0;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q   <= {1'b0, count_q, out_name};
      out_status_q <= cmd_i.out_status;
    end
  end

  assign stat_o.scan_done    = hit || (!pend_q && (idx_q >= count_q));
  assign stat_o.found        = found_q;
  assign stat_o.slot_is_last = (slot_q == last_idx);
  assign stat_o.full         = (count_q == CntW'(Depth));
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

endmodule

FILE: rtl/krt_ctrl.sv
// ----------------------------------------------------------------------------
// krt_ctrl
// command sequencer: accept, key scan, table action (with a record move on delete), result hand-off
// ----------------------------------------------------------------------------
module krt_ctrl
  import krt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_op_i,
  input  krt_stat_t  stat_i,
  output krt_cmd_t   cmd_o
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SScan   = 3'd1;
  localparam logic [2:0] SAct    = 3'd2;
  localparam logic [2:0] SMove   = 3'd3;
  localparam logic [2:0] SFinish = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  logic [1:0] status_q, status_d;
  logic       sel_q, sel_d;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    status_d = status_q;
    sel_d    = sel_q;
    cmd_o    = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          op_d          = in_op_i;
          state_d       = SScan;
        end
      end
      SScan: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.scan_done) begin
          state_d = SAct;
        end
      end
      SAct: begin
        status_d = StDone;
        sel_d    = 1'b0;
        state_d  = SFinish;
        case (op_q)
          OpInsert: begin
            if (stat_i.found) begin
              status_d = StDup;
            end else if (stat_i.full) begin
              status_d = StFull;
            end else begin
              cmd_o.wr_ins  = 1'b1;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          OpDelete: begin
            if (!stat_i.found) begin
              status_d = StMissing;
            end else if (stat_i.slot_is_last) begin
              cmd_o.cnt_dec = 1'b1;
            end else begin
              cmd_o.rd_last = 1'b1;
              state_d       = SMove;
            end
          end
          OpSelect: begin
            if (!stat_i.found) begin
              status_d = StMissing;
            end else begin
              sel_d = 1'b1;
            end
          end
          default: begin
            if (!stat_i.found) begin
              status_d = StMissing;
            end else begin
              cmd_o.wr_upd = 1'b1;
            end
          end
        endcase
      end
      SMove: begin
        cmd_o.wr_move = 1'b1;
        cmd_o.cnt_dec = 1'b1;
        state_d       = SFinish;
      end
      SFinish: begin
        cmd_o.sel_name   = sel_q;
        cmd_o.out_status = status_q;
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    sel_q    <= sel_d;
  end

endmodule

FILE: rtl/keyed_record_table.sv
// ----------------------------------------------------------------------------
// keyed_record_table
// associative table of up to 64 records, each a unique signed 32-bit key and
// a 49-byte name, driven by insert, delete, select and update words
// ----------------------------------------------------------------------------
// usage:
//  - one command word in on the slave stream, one result word out on the
//    master stream, always exactly one result per command
//  - the command is taken in the idle state only; tready then drops until
//    the result has been placed in the output register
//  - the next command is taken in the cycle after the result is loaded
//  - the search time is set by the key scan, one record read per cycle from
//    the single record memory read port, each compared in the cycle after
//    it is read
//  - the result sits in an output register, so the next command is taken
//    and searched while a result is still waiting on a stalled receiver;
//    only the hand-off of that next result waits for tready
//  - names are stored with every byte after the first zero byte cleared
//  - reset empties the table (record count to zero) and drops any pending
//    result; the record memory itself is not cleared
// ----------------------------------------------------------------------------
module keyed_record_table
  import krt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // low to high: key, name_w0 .. name_w5, name_b48
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // cmd
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // low to high: out_w0 .. out_w5, out_b48, records_held, one zero pad bit
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // status
  output logic [1:0]          m_axis_tuser_o
);

  krt_cmd_t  cmd;
  krt_stat_t stat;

  // sequencer: walks each command through search, action and hand-off
  krt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_op_i    (s_axis_tuser_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // record memory, search compare, count and output register
  krt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (s_axis_tdata_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule

FILE: bench/keyed_record_table_tb.sv
// ----------------------------------------------------------------------------
// keyed_record_table_tb
// self-checking bench for the keyed record table: commands go in on the slave
// stream with bursty gaps, results come out under a varying stall pattern,
// and every result word is checked field by field against a mirror table
// ----------------------------------------------------------------------------
module keyed_record_table_tb
  import krt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PoolSize   = 96;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned TailWait   = 80;

  typedef struct packed {
    logic [1:0]       status;
    logic [NameW-1:0] name;
    logic [CntW-1:0]  held;
  } table_result_t;

  typedef struct {
    logic [1:0]       op;
    logic [KeyW-1:0]  key;
    logic [NameW-1:0] name;
    bit               typed;
    table_result_t    want;
  } directed_row_t;

  typedef enum int {ReadyAlways, ReadyCoin, ReadyEveryFourth, ReadyMostly} stall_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // low to high: key, name_w0 .. name_w5, name_b48
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  // cmd
  logic [1:0]          s_axis_tuser_i = OpInsert;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // low to high: out_w0 .. out_w5, out_b48, records_held, pad bit
  logic [OutDataW-1:0] m_axis_tdata_o;
  // status
  logic [1:0]          m_axis_tuser_o;

  // mirror of the table contents, only slots below mirror_count are valid
  logic [KeyW-1:0]  mirror_keys  [Depth];
  logic [NameW-1:0] mirror_names [Depth];
  int unsigned      mirror_count;

  table_result_t    expected_results [$];
  directed_row_t    directed_rows [$];
  logic [KeyW-1:0]  key_pool [PoolSize];

  int unsigned errors;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned status_hits [4];
  int unsigned peak_count;
  int unsigned burst_left;
  int unsigned idle_cycles;
  bit          offering;
  bit          hold_req;

  always #5ns clk_i = ~clk_i;

  keyed_record_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // ---------------------------------------------------------------- mirror

  // slot holding the key, Depth when absent
  function automatic int unsigned find_slot(logic [KeyW-1:0] key);
    for (int unsigned i = 0; i < mirror_count; i++) begin
      if (mirror_keys[i] == key) return i;
    end
    return Depth;
  endfunction

  // clear every byte after the first zero byte
  function automatic logic [NameW-1:0] strip_name(logic [NameW-1:0] raw);
    logic [NameW-1:0] clean;
    bit               ended;
    clean = raw;
    ended = 1'b0;
    for (int i = 0; i < NameBytes; i++) begin
      if (ended) clean[8*i +: 8] = 8'h00;
      else if (raw[8*i +: 8] == 8'h00) ended = 1'b1;
    end
    return clean;
  endfunction

  // apply one command to the mirror and return the result word it yields
  function automatic table_result_t table_apply(logic [1:0] op, logic [KeyW-1:0] key,
                                                logic [NameW-1:0] name);
    table_result_t res;
    int unsigned   slot;
    int unsigned   last;
    res  = '{status: StDone, name: '0, held: '0};
    slot = find_slot(key);
    case (op)
      OpInsert: begin
        if (slot != Depth) begin
          res.status = StDup;
        end else if (mirror_count >= Depth) begin
          res.status = StFull;
        end else begin
          mirror_keys[mirror_count]  = key;
          mirror_names[mirror_count] = strip_name(name);
          mirror_count++;
        end
      end
      OpDelete: begin
        if (slot == Depth) begin
          res.status = StMissing;
        end else begin
          // the last record fills the hole unless it is the one dropped
          last = mirror_count - 1;
          if (slot != last) begin
            mirror_keys[slot]  = mirror_keys[last];
            mirror_names[slot] = mirror_names[last];
          end
          mirror_count = last;
        end
      end
      OpSelect: begin
        if (slot == Depth) res.status = StMissing;
        else res.name = mirror_names[slot];
      end
      default: begin
        if (slot == Depth) res.status = StMissing;
        else mirror_names[slot] = strip_name(name);
      end
    endcase
    res.held = CntW'(mirror_count);
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [NameW-1:0] rand_name();
    logic [NameW-1:0] n;
    for (int i = 0; i < NameBytes; i++) n[8*i +: 8] = 8'($urandom_range(255));
    case ($urandom_range(3))
      0: n[8*$urandom_range(NameBytes-1) +: 8] = 8'h00;
      1: n = '0;
      default: ;
    endcase
    return n;
  endfunction

  // a held key with hit_pct chance, else a pool key or a fully random one
  function automatic logic [KeyW-1:0] pick_key(int unsigned hit_pct);
    if (mirror_count > 0 && $urandom_range(99) < hit_pct)
      return mirror_keys[$urandom_range(mirror_count-1)];
    if ($urandom_range(3) != 0) return key_pool[$urandom_range(PoolSize-1)];
    return $urandom;
  endfunction

  function automatic logic [KeyW-1:0] fresh_key();
    logic [KeyW-1:0] k;
    do k = $urandom; while (find_slot(k) != Depth);
    return k;
  endfunction

  // offer one command word, predict on acceptance, then maybe leave a gap
  task automatic send_word(logic [1:0] op, logic [KeyW-1:0] key, logic [NameW-1:0] name,
                           bit typed = 1'b0, table_result_t want = '0);
    table_result_t predicted;
    int unsigned   gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {name, key};
    s_axis_tuser_i  <= op;
    offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = table_apply(op, key, name);
    expected_results.push_back(typed ? want : predicted);
    words_sent++;
    if (mirror_count > peak_count) peak_count = mirror_count;
    // bursts of back-to-back words separated by idle gaps
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = $urandom_range(1, 12);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_command(int unsigned hit_pct);
    logic [1:0]  op;
    int unsigned r;
    r = $urandom_range(99);
    // lean toward inserts on a near-empty table, deletes on a near-full one
    if (mirror_count < 12)
      op = (r < 55) ? OpInsert : (r < 70) ? OpDelete : (r < 85) ? OpSelect : OpUpdate;
    else if (mirror_count > 56)
      op = (r < 20) ? OpInsert : (r < 55) ? OpDelete : (r < 80) ? OpSelect : OpUpdate;
    else
      op = (r < 30) ? OpInsert : (r < 50) ? OpDelete : (r < 75) ? OpSelect : OpUpdate;
    send_word(op, pick_key(op == OpInsert ? hit_pct / 4 : hit_pct), rand_name());
  endtask

  // stop offering and wait until every expected result word has arrived
  task automatic drain_results();
    if (offering) begin
      s_axis_tvalid_i <= 1'b0;
      offering = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(logic [1:0] op, logic [KeyW-1:0] key, logic [NameW-1:0] name,
                         bit typed = 1'b0, logic [1:0] st = StDone, int unsigned held = 0);
    directed_row_t row;
    row.op    = op;
    row.key   = key;
    row.name  = name;
    row.typed = typed;
    row.want  = '{status: st, name: '0, held: CntW'(held)};
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------- receiver

  // stall pattern switches among four modes, each held for a random run; a hold request forces a
  // long stretch of tready low so the block backs up into its input
  initial begin
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = ReadyAlways;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          ReadyAlways:      m_axis_tready_i <= 1'b1;
          ReadyCoin:        m_axis_tready_i <= 1'($urandom_range(1));
          ReadyEveryFourth: m_axis_tready_i <= (tick % 4 == 0);
          default:          m_axis_tready_i <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin : result_check
    table_result_t    want;
    logic [NameW-1:0] got_name;
    logic [CntW-1:0]  got_held;
    logic [63:0]      want_f;
    logic [63:0]      got_f;
    string            label;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      status_hits[m_axis_tuser_o]++;
      got_name = m_axis_tdata_o[NameW-1:0];
      got_held = m_axis_tdata_o[NameW +: CntW];
      if (expected_results.size() == 0) begin
        $display("%0t: result word with none expected: status %0d records_held %0d",
                 $time, m_axis_tuser_o, got_held);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   m_axis_tuser_o);
          errors++;
        end
        for (int f = 0; f < 7; f++) begin
          want_f = (f < 6) ? want.name[64*f +: 64] : 64'(want.name[384 +: 8]);
          got_f  = (f < 6) ? got_name[64*f +: 64] : 64'(got_name[384 +: 8]);
          label  = (f < 6) ? $sformatf("out_w%0d", f) : "out_b48";
          if (got_f !== want_f) begin
            $display("%0t: %s expected %h actual %h", $time, label, want_f, got_f);
            errors++;
          end
        end
        if (got_held !== want.held) begin
          $display("%0t: records_held expected %0d actual %0d", $time, want.held,
                   got_held);
          errors++;
        end
      end
    end
  end

  // nothing moving on either side for too long means the block hung
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
               IdleLimit, expected_results.size());
      $display("keyed_record_table_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    logic [NameW-1:0] all_ones;
    logic [NameW-1:0] first_zero;
    logic [NameW-1:0] mid_zero;
    logic [NameW-1:0] late_zero;
    logic [KeyW-1:0]  kmin;
    logic [KeyW-1:0]  kmax;
    logic [KeyW-1:0]  kneg;

    errors       = 0;
    words_sent   = 0;
    results_seen = 0;
    peak_count   = 0;
    burst_left   = 0;
    idle_cycles  = 0;
    offering     = 1'b0;
    hold_req     = 1'b0;
    mirror_count = 0;
    foreach (status_hits[i]) status_hits[i] = 0;

    all_ones   = {NameBytes{8'hFF}};
    first_zero = {{(NameBytes-1){8'hA5}}, 8'h00};
    mid_zero   = {{28{8'h5A}}, 8'h00, {20{8'h3C}}};
    late_zero  = {8'h11, 8'h00, {47{8'h22}}};   // byte 47 zero, so byte 48 is cleared
    kmin       = 32'h8000_0000;
    kmax       = 32'h7FFF_FFFF;
    kneg       = 32'hFFFF_FFFF;

    key_pool[0] = kmin;
    key_pool[1] = kmax;
    key_pool[2] = '0;
    key_pool[3] = kneg;
    key_pool[4] = 32'd1;
    for (int i = 5; i < PoolSize; i++) key_pool[i] = $urandom;

    // directed rows: empty table, extreme keys, name termination cases,
    // duplicate insert, misses, delete with a move and delete of the last slot
    add_row(OpSelect, '0,     '0,         1'b1, StMissing, 0);
    add_row(OpDelete, '0,     '0,         1'b1, StMissing, 0);
    add_row(OpUpdate, '0,     all_ones,   1'b1, StMissing, 0);
    add_row(OpInsert, kmin,   all_ones,   1'b1, StDone,    1);
    add_row(OpInsert, kmax,   first_zero, 1'b1, StDone,    2);
    add_row(OpInsert, '0,     mid_zero,   1'b1, StDone,    3);
    add_row(OpInsert, kneg,   '0,         1'b1, StDone,    4);
    add_row(OpInsert, 32'd1,  late_zero,  1'b1, StDone,    5);
    add_row(OpInsert, kmin,   mid_zero,   1'b1, StDup,     5);
    add_row(OpSelect, kmin,   '0);
    add_row(OpSelect, kmax,   '0);
    add_row(OpSelect, '0,     '0);
    add_row(OpSelect, kneg,   all_ones);
    add_row(OpSelect, 32'd1,  '0);
    add_row(OpUpdate, kmax,   all_ones,   1'b1, StDone,    5);
    add_row(OpSelect, kmax,   '0);
    add_row(OpUpdate, 32'd2,  all_ones,   1'b1, StMissing, 5);
    add_row(OpDelete, 32'd2,  '0,         1'b1, StMissing, 5);
    add_row(OpDelete, kmin,   all_ones,   1'b1, StDone,    4);
    add_row(OpSelect, 32'd1,  {NameBytes{8'h77}});
    add_row(OpSelect, kmin,   '0,         1'b1, StMissing, 4);
    add_row(OpDelete, kneg,   '0,         1'b1, StDone,    3);
    add_row(OpDelete, 32'd1,  '0,         1'b1, StDone,    2);
    add_row(OpDelete, '0,     '0,         1'b1, StDone,    1);
    add_row(OpDelete, kmax,   '0,         1'b1, StDone,    0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].key, directed_rows[i].name,
                directed_rows[i].typed, directed_rows[i].want);

    // fill the table to the brim, then probe it while full
    while (mirror_count < Depth) send_word(OpInsert, fresh_key(), rand_name());
    repeat (3) send_word(OpInsert, fresh_key(), rand_name());
    repeat (2) send_word(OpInsert, pick_key(100), rand_name());
    repeat (60) send_random_command(70);

    // receiver holds off while the sender keeps offering words
    hold_req = 1'b1;
    repeat (12) send_random_command(70);

    // sender pauses until the table has answered everything
    drain_results();

    // empty the table through random slots, the last slot among them
    while (mirror_count > 0)
      send_word(OpDelete, mirror_keys[$urandom_range(mirror_count-1)], rand_name());

    repeat (380) send_random_command(60);

    drain_results();
    repeat (TailWait) @(posedge clk_i);

    $display("%0d command words, %0d result words, peak table fill %0d of %0d", words_sent,
             results_seen, peak_count, Depth);
    $display("statuses seen: done %0d, duplicate %0d, full %0d, not found %0d",
             status_hits[StDone], status_hits[StDup], status_hits[StFull],
             status_hits[StMissing]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("keyed_record_table_tb OK");
    end else begin
      $display("keyed_record_table_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/krt_pkg.sv
rtl/krt_datapath.sv
rtl/krt_ctrl.sv
rtl/keyed_record_table.sv
bench/keyed_record_table_tb.sv
